// ----- rtl/core/sstb_pkg.sv -----
// ----------------------------------------------------------------------------
// sstb_pkg
// Shared constants, codes and types of the scaled transparent sprite blitter.
// ----------------------------------------------------------------------------
package sstb_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int MAX_SCALE     = 8;
   localparam int MAX_PIC_DIM   = 1024;

   // fixed field widths
   localparam int CMD_W      = 2;
   localparam int PIX_W      = 8;
   localparam int DEST_W     = 12;
   localparam int PIC_W      = 11;
   localparam int SCL_RAW_W  = 4;
   localparam int SCR_W      = 13;
   localparam int MODE_W     = 9;
   localparam int ADDR_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // derived widths
   localparam int TBL_AW  = $clog2(TABLE_ENTRIES);
   localparam int SCALE_W = $clog2(MAX_SCALE + 1);
   localparam int POS_W   = $clog2(MAX_PIC_DIM);
   localparam int DIM_W   = $clog2(MAX_PIC_DIM + 1);
   localparam int PROD_W  = POS_W + SCALE_W;
   localparam int OFS_W   = ((PROD_W > DEST_W) ? PROD_W : DEST_W) + 1;
   localparam int CMP_W   = ((OFS_W > SCR_W) ? OFS_W : SCR_W) + 1;
   localparam int MUL_W   = OFS_W + SCR_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PIXEL = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_START = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEST_X        = 3'd0,
      REG_DEST_Y        = 3'd1,
      REG_PIC_WIDTH     = 3'd2,
      REG_PIC_HEIGHT    = 3'd3,
      REG_SCALE_FACTOR  = 3'd4,
      REG_SCREEN_WIDTH  = 3'd5,
      REG_SCREEN_HEIGHT = 3'd6,
      REG_MODE_FLAGS    = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_BASE,
      ST_EMIT
   } gen_state_type;

   // configuration after range clamping
   typedef struct packed {
      logic [DEST_W-1:0]  dest_x;
      logic [DEST_W-1:0]  dest_y;
      logic [DIM_W-1:0]   pic_w;
      logic [DIM_W-1:0]   pic_h;
      logic [SCALE_W-1:0] scale;
      logic [SCR_W-1:0]   scr_w;
      logic [SCR_W-1:0]   scr_h;
      logic [PIX_W-1:0]   key;
      logic               xlat_en;
   } cfg_type;

   // translation table access
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [TBL_AW-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } tbl_req_type;

endpackage

// ----- rtl/core/sstb_if.sv -----
// ----------------------------------------------------------------------------
// sstb channel interfaces
// Valid/ready channels for requests, framebuffer writes and register writes.
// ----------------------------------------------------------------------------
interface sstb_req_if;
   logic                       valid;
   logic                       ready;
   logic [sstb_pkg::CMD_W-1:0] command;
   logic [sstb_pkg::PIX_W-1:0] table_index;
   logic [sstb_pkg::PIX_W-1:0] value;

   modport source (output valid, command, table_index, value, input ready);
   modport sink   (input valid, command, table_index, value, output ready);
endinterface

interface sstb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sstb_pkg::ADDR_W-1:0] write_address;
   logic [sstb_pkg::PIX_W-1:0]  write_value;
   logic                        last_write;

   modport source (output valid, write_address, write_value, last_write, input ready);
   modport sink   (input valid, write_address, write_value, last_write, output ready);
endinterface

interface sstb_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sstb_pkg::CSR_IDX_W-1:0]  index;
   logic [sstb_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/scaled_transparent_sprite_blitter_top.sv -----
// ----------------------------------------------------------------------------
// scaled_transparent_sprite_blitter_top
// Color-keyed, integer-scaled sprite blitter producing framebuffer writes.
// ----------------------------------------------------------------------------
// One request is processed at a time. Load, start, unused-code and transparent
// pixel requests pass through decode and return to idle. An opaque pixel goes
// through setup (decode, table read, row-offset multiply, base add) and
// then issues its visible writes, up to scale squared, at one write per
// cycle while the write channel takes them; the last write may still wait in
// the output register while the next request is taken. The 256x8 translation
// table is a single-port synchronous RAM with no clearing pass after reset:
// load every entry used before enabling translation.
module scaled_transparent_sprite_blitter_top (
   input  logic        clock,
   input  logic        reset,
   sstb_req_if.sink    req_port,
   sstb_rsp_if.source  rsp_port,
   sstb_csr_if.sink    csr_port
);

   sstb_pkg::cfg_type          cfg;
   sstb_pkg::tbl_req_type      tbl_req;
   logic [sstb_pkg::PIX_W-1:0] tbl_rdata;

   sstb_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   sstb_xlat u_xlat (
      .clock   (clock),
      .tbl_req (tbl_req),
      .rdata   (tbl_rdata)
   );

   sstb_gen u_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_port  (req_port),
      .rsp_port  (rsp_port),
      .tbl_req   (tbl_req),
      .tbl_rdata (tbl_rdata)
   );

endmodule

// ----- rtl/core/sstb_xlat.sv -----
// ----------------------------------------------------------------------------
// sstb_xlat
// Translation table: single-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sstb_xlat (
   input  logic                       clock,
   input  sstb_pkg::tbl_req_type      tbl_req,
   output logic [sstb_pkg::PIX_W-1:0] rdata
);

   logic [sstb_pkg::PIX_W-1:0] mem [sstb_pkg::TABLE_ENTRIES];
   logic [sstb_pkg::PIX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.addr] <= tbl_req.wdata;
      end
      if (tbl_req.rd_en) begin
         rdata_ff <= mem[tbl_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/sstb_csr.sv -----
// ----------------------------------------------------------------------------
// sstb_csr
// Configuration registers with range clamping of scale and picture size.
// ----------------------------------------------------------------------------
module sstb_csr (
   input  logic                 clock,
   input  logic                 reset,
   sstb_csr_if.sink             csr_port,
   output sstb_pkg::cfg_type    cfg
);

   logic [sstb_pkg::DEST_W-1:0]    dest_x_ff;
   logic [sstb_pkg::DEST_W-1:0]    dest_y_ff;
   logic [sstb_pkg::PIC_W-1:0]     pic_w_ff;
   logic [sstb_pkg::PIC_W-1:0]     pic_h_ff;
   logic [sstb_pkg::SCL_RAW_W-1:0] scale_ff;
   logic [sstb_pkg::SCR_W-1:0]     scr_w_ff;
   logic [sstb_pkg::SCR_W-1:0]     scr_h_ff;
   logic [sstb_pkg::MODE_W-1:0]    mode_ff;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff <= '0;
         dest_y_ff <= '0;
         pic_w_ff  <= sstb_pkg::PIC_W'(1);
         pic_h_ff  <= sstb_pkg::PIC_W'(1);
         scale_ff  <= sstb_pkg::SCL_RAW_W'(1);
         scr_w_ff  <= sstb_pkg::SCR_W'(320);
         scr_h_ff  <= sstb_pkg::SCR_W'(200);
         mode_ff   <= sstb_pkg::MODE_W'(255);
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            sstb_pkg::REG_DEST_X:        dest_x_ff <= csr_port.data[sstb_pkg::DEST_W-1:0];
            sstb_pkg::REG_DEST_Y:        dest_y_ff <= csr_port.data[sstb_pkg::DEST_W-1:0];
            sstb_pkg::REG_PIC_WIDTH:     pic_w_ff  <= csr_port.data[sstb_pkg::PIC_W-1:0];
            sstb_pkg::REG_PIC_HEIGHT:    pic_h_ff  <= csr_port.data[sstb_pkg::PIC_W-1:0];
            sstb_pkg::REG_SCALE_FACTOR:  scale_ff  <= csr_port.data[sstb_pkg::SCL_RAW_W-1:0];
            sstb_pkg::REG_SCREEN_WIDTH:  scr_w_ff  <= csr_port.data[sstb_pkg::SCR_W-1:0];
            sstb_pkg::REG_SCREEN_HEIGHT: scr_h_ff  <= csr_port.data[sstb_pkg::SCR_W-1:0];
            sstb_pkg::REG_MODE_FLAGS:    mode_ff   <= csr_port.data[sstb_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg         = '0;
      cfg.dest_x  = dest_x_ff;
      cfg.dest_y  = dest_y_ff;
      cfg.scr_w   = scr_w_ff;
      cfg.scr_h   = scr_h_ff;
      cfg.key     = mode_ff[sstb_pkg::PIX_W-1:0];
      cfg.xlat_en = mode_ff[sstb_pkg::PIX_W];

      // zero acts as one, oversize acts as the maximum
      if (pic_w_ff == '0) begin
         cfg.pic_w = sstb_pkg::DIM_W'(1);
      end else if (32'(pic_w_ff) > sstb_pkg::MAX_PIC_DIM) begin
         cfg.pic_w = sstb_pkg::DIM_W'(sstb_pkg::MAX_PIC_DIM);
      end else begin
         cfg.pic_w = sstb_pkg::DIM_W'(pic_w_ff);
      end

      if (pic_h_ff == '0) begin
         cfg.pic_h = sstb_pkg::DIM_W'(1);
      end else if (32'(pic_h_ff) > sstb_pkg::MAX_PIC_DIM) begin
         cfg.pic_h = sstb_pkg::DIM_W'(sstb_pkg::MAX_PIC_DIM);
      end else begin
         cfg.pic_h = sstb_pkg::DIM_W'(pic_h_ff);
      end

      if (scale_ff == '0) begin
         cfg.scale = sstb_pkg::SCALE_W'(1);
      end else if (32'(scale_ff) > sstb_pkg::MAX_SCALE) begin
         cfg.scale = sstb_pkg::SCALE_W'(sstb_pkg::MAX_SCALE);
      end else begin
         cfg.scale = sstb_pkg::SCALE_W'(scale_ff);
      end
   end

endmodule

// ----- rtl/core/sstb_gen.sv -----
// ----------------------------------------------------------------------------
// sstb_gen
// Command sequencer and write generator: position counters, table access,
// clipping and the framebuffer write output register.
// ----------------------------------------------------------------------------
module sstb_gen (
   input  logic                       clock,
   input  logic                       reset,
   input  sstb_pkg::cfg_type          cfg,
   sstb_req_if.sink                   req_port,
   sstb_rsp_if.source                 rsp_port,
   output sstb_pkg::tbl_req_type      tbl_req,
   input  logic [sstb_pkg::PIX_W-1:0] tbl_rdata
);

   sstb_pkg::gen_state_type state_ff, state_in;

   logic [sstb_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [sstb_pkg::PIX_W-1:0]   idx_ff, idx_in;
   logic [sstb_pkg::PIX_W-1:0]   val_ff, val_in;
   logic [sstb_pkg::POS_W-1:0]   col_ff, col_in;
   logic [sstb_pkg::POS_W-1:0]   row_ff, row_in;
   logic [sstb_pkg::OFS_W-1:0]   ox0_ff, ox0_in;
   logic [sstb_pkg::OFS_W-1:0]   oy0_ff, oy0_in;
   logic [sstb_pkg::PIX_W-1:0]   pix_ff, pix_in;
   logic [sstb_pkg::MUL_W-1:0]   prod_ff, prod_in;
   logic                         clip_ff, clip_in;
   logic [sstb_pkg::SCALE_W-1:0] ni_last_ff, ni_last_in;
   logic [sstb_pkg::SCALE_W-1:0] nk_last_ff, nk_last_in;
   logic [sstb_pkg::SCALE_W-1:0] i_ff, i_in;
   logic [sstb_pkg::SCALE_W-1:0] k_ff, k_in;
   logic [sstb_pkg::ADDR_W-1:0]  cur_ff, cur_in;
   logic [sstb_pkg::ADDR_W-1:0]  row_addr_ff, row_addr_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sstb_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [sstb_pkg::PIX_W-1:0]   rsp_val_ff, rsp_val_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         out_free;
   logic                         emit_load;
   logic [sstb_pkg::POS_W-1:0]   col_eff, row_eff;
   logic [sstb_pkg::DIM_W-1:0]   col_nx, row_nx;
   logic [sstb_pkg::PROD_W-1:0]  col_mul, row_mul;
   logic [sstb_pkg::CMP_W-1:0]   x_room, y_room;
   logic [sstb_pkg::SCALE_W-1:0] ni, nk;
   logic [sstb_pkg::ADDR_W-1:0]  pitch;

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign pitch    = sstb_pkg::ADDR_W'(cfg.scr_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sstb_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      ox0_ff      <= ox0_in;
      oy0_ff      <= oy0_in;
      pix_ff      <= pix_in;
      prod_ff     <= prod_in;
      clip_ff     <= clip_in;
      ni_last_ff  <= ni_last_in;
      nk_last_ff  <= nk_last_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      cur_ff      <= cur_in;
      row_addr_ff <= row_addr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      ox0_in      = ox0_ff;
      oy0_in      = oy0_ff;
      pix_in      = pix_ff;
      prod_in     = prod_ff;
      clip_in     = clip_ff;
      ni_last_in  = ni_last_ff;
      nk_last_in  = nk_last_ff;
      i_in        = i_ff;
      k_in        = k_ff;
      cur_in      = cur_ff;
      row_addr_in = row_addr_ff;
      rsp_addr_in = rsp_addr_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_last_in = rsp_last_ff;
      emit_load   = 1'b0;
      tbl_req     = '0;
      req_port.ready = 1'b0;

      // position clamp and advance, used by a pixel request
      col_eff = ({1'b0, col_ff} >= cfg.pic_w) ? '0 : col_ff;
      row_eff = ({1'b0, row_ff} >= cfg.pic_h) ? '0 : row_ff;
      col_nx  = sstb_pkg::DIM_W'(col_eff) + sstb_pkg::DIM_W'(1);
      row_nx  = sstb_pkg::DIM_W'(row_eff) + sstb_pkg::DIM_W'(1);
      col_mul = sstb_pkg::PROD_W'(col_eff) * sstb_pkg::PROD_W'(cfg.scale);
      row_mul = sstb_pkg::PROD_W'(row_eff) * sstb_pkg::PROD_W'(cfg.scale);

      // visible span of the block in each direction
      x_room = sstb_pkg::CMP_W'(cfg.scr_w) - sstb_pkg::CMP_W'(ox0_ff);
      y_room = sstb_pkg::CMP_W'(cfg.scr_h) - sstb_pkg::CMP_W'(oy0_ff);
      if (sstb_pkg::CMP_W'(ox0_ff) >= sstb_pkg::CMP_W'(cfg.scr_w)) begin
         ni = '0;
      end else if (x_room >= sstb_pkg::CMP_W'(cfg.scale)) begin
         ni = cfg.scale;
      end else begin
         ni = x_room[sstb_pkg::SCALE_W-1:0];
      end
      if (sstb_pkg::CMP_W'(oy0_ff) >= sstb_pkg::CMP_W'(cfg.scr_h)) begin
         nk = '0;
      end else if (y_room >= sstb_pkg::CMP_W'(cfg.scale)) begin
         nk = cfg.scale;
      end else begin
         nk = y_room[sstb_pkg::SCALE_W-1:0];
      end

      unique case (state_ff)
         sstb_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               cmd_in   = req_port.command;
               idx_in   = req_port.table_index;
               val_in   = req_port.value;
               state_in = sstb_pkg::ST_DECODE;
            end
         end

         sstb_pkg::ST_DECODE: begin
            state_in = sstb_pkg::ST_IDLE;
            unique case (cmd_ff)
               sstb_pkg::CMD_LOAD: begin
                  tbl_req.wr_en = 1'b1;
                  tbl_req.addr  = sstb_pkg::TBL_AW'(idx_ff);
                  tbl_req.wdata = val_ff;
               end
               sstb_pkg::CMD_START: begin
                  col_in = '0;
                  row_in = '0;
               end
               sstb_pkg::CMD_PIXEL: begin
                  ox0_in = sstb_pkg::OFS_W'(cfg.dest_x) + sstb_pkg::OFS_W'(col_mul);
                  oy0_in = sstb_pkg::OFS_W'(cfg.dest_y) + sstb_pkg::OFS_W'(row_mul);
                  // advance even when nothing gets drawn
                  if (col_nx >= cfg.pic_w) begin
                     col_in = '0;
                     row_in = (row_nx >= cfg.pic_h) ? '0 : row_nx[sstb_pkg::POS_W-1:0];
                  end else begin
                     col_in = col_nx[sstb_pkg::POS_W-1:0];
                     row_in = row_eff;
                  end
                  if (val_ff != cfg.key) begin
                     tbl_req.rd_en = 1'b1;
                     tbl_req.addr  = sstb_pkg::TBL_AW'(val_ff);
                     state_in      = sstb_pkg::ST_FETCH;
                  end
               end
               default: ;
            endcase
         end

         sstb_pkg::ST_FETCH: begin
            pix_in     = cfg.xlat_en ? tbl_rdata : val_ff;
            prod_in    = sstb_pkg::MUL_W'(oy0_ff) * sstb_pkg::MUL_W'(cfg.scr_w);
            clip_in    = (ni == '0) || (nk == '0);
            ni_last_in = ni - sstb_pkg::SCALE_W'(1);
            nk_last_in = nk - sstb_pkg::SCALE_W'(1);
            state_in   = sstb_pkg::ST_BASE;
         end

         sstb_pkg::ST_BASE: begin
            cur_in      = prod_ff[sstb_pkg::ADDR_W-1:0] + sstb_pkg::ADDR_W'(ox0_ff);
            row_addr_in = prod_ff[sstb_pkg::ADDR_W-1:0] + sstb_pkg::ADDR_W'(ox0_ff);
            i_in        = '0;
            k_in        = '0;
            state_in    = clip_ff ? sstb_pkg::ST_IDLE : sstb_pkg::ST_EMIT;
         end

         sstb_pkg::ST_EMIT: begin
            if (out_free) begin
               emit_load   = 1'b1;
               rsp_addr_in = cur_ff;
               rsp_val_in  = pix_ff;
               rsp_last_in = (i_ff == ni_last_ff) && (k_ff == nk_last_ff);
               if (i_ff == ni_last_ff) begin
                  i_in        = '0;
                  k_in        = k_ff + sstb_pkg::SCALE_W'(1);
                  row_addr_in = row_addr_ff + pitch;
                  cur_in      = row_addr_ff + pitch;
               end else begin
                  i_in   = i_ff + sstb_pkg::SCALE_W'(1);
                  cur_in = cur_ff + sstb_pkg::ADDR_W'(1);
               end
               if (rsp_last_in) begin
                  state_in = sstb_pkg::ST_IDLE;
               end
            end
         end

         default: state_in = sstb_pkg::ST_IDLE;
      endcase

      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.write_address = rsp_addr_ff;
   assign rsp_port.write_value   = rsp_val_ff;
   assign rsp_port.last_write    = rsp_last_ff;

   a_emit_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstb_pkg::ST_EMIT) |-> (i_ff <= ni_last_ff) && (k_ff <= nk_last_ff))
      else $error("write counters left the visible block");

   a_read_then_fetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstb_pkg::ST_DECODE && tbl_req.rd_en) |=> (state_ff == sstb_pkg::ST_FETCH))
      else $error("table read data not consumed in the following cycle");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (emit_load && rsp_last_in) |=> (state_ff == sstb_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("final write did not return the sequencer to idle");

   a_no_load_on_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sstb_pkg::ST_IDLE) |=> !$past(emit_load))
      else $error("write issued outside the emit phase");

endmodule

// ----- tb/tb_scaled_transparent_sprite_blitter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scaled_transparent_sprite_blitter_top
// Self-checking bench for the sprite blitter: a queue-fed request driver, a
// framebuffer write monitor and a behavioral blit predictor. Directed requests
// cover clipping, transparency, translation, picture wrap, restart and the
// unused command. Random phases follow, each under a new register setup and
// with its own percentages of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_scaled_transparent_sprite_blitter_top;

   localparam logic [sstb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [sstb_pkg::CMD_W-1:0] cmd;
      logic [sstb_pkg::PIX_W-1:0] tbl_idx;
      logic [sstb_pkg::PIX_W-1:0] value;
   } blit_req_type;

   typedef struct packed {
      logic [sstb_pkg::ADDR_W-1:0] addr;
      logic [sstb_pkg::PIX_W-1:0]  pix;
      logic                        last;
   } fb_write_type;

   logic clock;
   logic reset;

   sstb_req_if req_bus ();
   sstb_rsp_if rsp_bus ();
   sstb_csr_if csr_bus ();

   scaled_transparent_sprite_blitter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // register copies seen by the predictor
   logic [sstb_pkg::DEST_W-1:0]    cfg_dest_x;
   logic [sstb_pkg::DEST_W-1:0]    cfg_dest_y;
   logic [sstb_pkg::PIC_W-1:0]     cfg_pic_w;
   logic [sstb_pkg::PIC_W-1:0]     cfg_pic_h;
   logic [sstb_pkg::SCL_RAW_W-1:0] cfg_scale;
   logic [sstb_pkg::SCR_W-1:0]     cfg_scr_w;
   logic [sstb_pkg::SCR_W-1:0]     cfg_scr_h;
   logic [sstb_pkg::MODE_W-1:0]    cfg_mode;

   logic [sstb_pkg::PIX_W-1:0] xlat_mem [sstb_pkg::TABLE_ENTRIES];
   logic                       tbl_loaded [sstb_pkg::TABLE_ENTRIES];
   int unsigned                src_col;
   int unsigned                src_row;

   blit_req_type req_items [$];
   fb_write_type fb_expect_q [$];

   int  send_idle_pct;
   int  recv_stall_pct;
   int  mismatch_count;
   logic hold_req;
   logic rsp_hold;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v == 0)
         return 1;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic logic [sstb_pkg::PIX_W-1:0] rand_byte();
      return sstb_pkg::PIX_W'($urandom_range(255));
   endfunction

   // Work out the framebuffer writes of one accepted request.
   task automatic blit_predict(input logic [sstb_pkg::CMD_W-1:0] cmd,
                               input logic [sstb_pkg::PIX_W-1:0] idx,
                               input logic [sstb_pkg::PIX_W-1:0] val);
      int unsigned s, w, h, col, row, ox, oy;
      logic [sstb_pkg::PIX_W-1:0] pix;
      fb_write_type wr;
      fb_write_type blk [$];
      case (cmd)
         sstb_pkg::CMD_LOAD: xlat_mem[idx] = val;
         sstb_pkg::CMD_START: begin
            src_col = 0;
            src_row = 0;
         end
         sstb_pkg::CMD_PIXEL: begin
            s = clamp_dim(cfg_scale, sstb_pkg::MAX_SCALE);
            w = clamp_dim(cfg_pic_w, sstb_pkg::MAX_PIC_DIM);
            h = clamp_dim(cfg_pic_h, sstb_pkg::MAX_PIC_DIM);
            col = (src_col >= w) ? 0 : src_col;
            row = (src_row >= h) ? 0 : src_row;
            if (val != cfg_mode[sstb_pkg::PIX_W-1:0]) begin
               pix = cfg_mode[sstb_pkg::PIX_W] ? xlat_mem[val] : val;
               for (int unsigned k = 0; k < s; k++) begin
                  oy = cfg_dest_y + row * s + k;
                  if (oy >= cfg_scr_h)
                     break;
                  for (int unsigned i = 0; i < s; i++) begin
                     ox = cfg_dest_x + col * s + i;
                     if (ox >= cfg_scr_w)
                        break;
                     wr.addr = sstb_pkg::ADDR_W'(oy * cfg_scr_w + ox);
                     wr.pix  = pix;
                     wr.last = 1'b0;
                     blk.push_back(wr);
                  end
               end
               if (blk.size() != 0)
                  blk[blk.size()-1].last = 1'b1;
               foreach (blk[n])
                  fb_expect_q.push_back(blk[n]);
            end
            col++;
            if (col >= w) begin
               col = 0;
               row++;
               if (row >= h)
                  row = 0;
            end
            src_col = col;
            src_row = row;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : req_driver
      blit_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            blit_predict(req_bus.command, req_bus.table_index, req_bus.value);
         // hold an offered request until it is taken
         if (!req_bus.valid || req_bus.ready) begin
            if (req_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = req_items.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.command     <= nxt.cmd;
               req_bus.table_index <= nxt.tbl_idx;
               req_bus.value       <= nxt.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : fb_monitor
      fb_write_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (fb_expect_q.size() == 0) begin
               report_mismatch($sformatf("unexpected write addr %h value %h last %b",
                                         rsp_bus.write_address, rsp_bus.write_value,
                                         rsp_bus.last_write));
            end else begin
               want = fb_expect_q.pop_front();
               if (rsp_bus.write_address !== want.addr)
                  report_mismatch($sformatf("write_address %h, want %h",
                                            rsp_bus.write_address, want.addr));
               if (rsp_bus.write_value !== want.pix)
                  report_mismatch($sformatf("write_value %h at %h, want %h",
                                            rsp_bus.write_value, want.addr, want.pix));
               if (rsp_bus.last_write !== want.last)
                  report_mismatch($sformatf("last_write %b at %h, want %b",
                                            rsp_bus.last_write, want.addr, want.last));
            end
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long output hold-off while requests keep coming
   initial begin : rsp_holdoff
      rsp_hold = 1'b0;
      wait (hold_req);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : watchdog
      #8000000;
      $display("[scaled_transparent_sprite_blitter_top] ERROR");
      $finish;
   end

   function automatic bit blit_busy();
      return req_items.size() != 0 || req_bus.valid || fb_expect_q.size() != 0;
   endfunction

   task automatic push_req(input logic [sstb_pkg::CMD_W-1:0] cmd,
                           input logic [sstb_pkg::PIX_W-1:0] idx,
                           input logic [sstb_pkg::PIX_W-1:0] val);
      blit_req_type it;
      it.cmd     = cmd;
      it.tbl_idx = idx;
      it.value   = val;
      req_items.push_back(it);
   endtask

   task automatic push_load(input logic [sstb_pkg::PIX_W-1:0] idx,
                            input logic [sstb_pkg::PIX_W-1:0] val);
      push_req(sstb_pkg::CMD_LOAD, idx, val);
      tbl_loaded[idx] = 1'b1;
   endtask

   // Load a table entry first if translation would read it unwritten.
   task automatic push_pixel(input logic [sstb_pkg::PIX_W-1:0] val);
      if (cfg_mode[sstb_pkg::PIX_W] && val != cfg_mode[sstb_pkg::PIX_W-1:0] && !tbl_loaded[val])
         push_load(val, rand_byte());
      push_req(sstb_pkg::CMD_PIXEL, rand_byte(), val);
   endtask

   // Wait for all requests and writes, then let trailing work settle.
   task automatic drain();
      while (blit_busy())
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input sstb_pkg::csr_reg_type r,
                            input logic [sstb_pkg::CSR_DATA_W-1:0] d);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= r;
      csr_bus.data  <= d;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      case (r)
         sstb_pkg::REG_DEST_X:        cfg_dest_x = d[sstb_pkg::DEST_W-1:0];
         sstb_pkg::REG_DEST_Y:        cfg_dest_y = d[sstb_pkg::DEST_W-1:0];
         sstb_pkg::REG_PIC_WIDTH:     cfg_pic_w  = d[sstb_pkg::PIC_W-1:0];
         sstb_pkg::REG_PIC_HEIGHT:    cfg_pic_h  = d[sstb_pkg::PIC_W-1:0];
         sstb_pkg::REG_SCALE_FACTOR:  cfg_scale  = d[sstb_pkg::SCL_RAW_W-1:0];
         sstb_pkg::REG_SCREEN_WIDTH:  cfg_scr_w  = d[sstb_pkg::SCR_W-1:0];
         sstb_pkg::REG_SCREEN_HEIGHT: cfg_scr_h  = d[sstb_pkg::SCR_W-1:0];
         sstb_pkg::REG_MODE_FLAGS:    cfg_mode   = d[sstb_pkg::MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic setup(input int dx, input int dy, input int pw, input int ph,
                        input int sc, input int sw, input int sh, input int mode);
      drain();
      csr_write(sstb_pkg::REG_DEST_X, sstb_pkg::CSR_DATA_W'(dx));
      csr_write(sstb_pkg::REG_DEST_Y, sstb_pkg::CSR_DATA_W'(dy));
      csr_write(sstb_pkg::REG_PIC_WIDTH, sstb_pkg::CSR_DATA_W'(pw));
      csr_write(sstb_pkg::REG_PIC_HEIGHT, sstb_pkg::CSR_DATA_W'(ph));
      csr_write(sstb_pkg::REG_SCALE_FACTOR, sstb_pkg::CSR_DATA_W'(sc));
      csr_write(sstb_pkg::REG_SCREEN_WIDTH, sstb_pkg::CSR_DATA_W'(sw));
      csr_write(sstb_pkg::REG_SCREEN_HEIGHT, sstb_pkg::CSR_DATA_W'(sh));
      csr_write(sstb_pkg::REG_MODE_FLAGS, sstb_pkg::CSR_DATA_W'(mode));
   endtask

   task automatic random_setup();
      int sc, pw, ph;
      sc = ($urandom_range(99) < 10) ? $urandom_range(15) : $urandom_range(1, 8);
      pw = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 12);
      ph = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 8);
      setup($urandom_range(400), $urandom_range(300), pw, ph, sc,
            $urandom_range(1, 640), $urandom_range(1, 480), $urandom_range(511));
   endtask

   // Mostly pixel streams from a picture start, some loads, restarts and noise.
   task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
      int roll;
      int j;
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      push_req(sstb_pkg::CMD_START, rand_byte(), rand_byte());
      j = 1;
      while (j < n_items) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            push_req(CMD_UNUSED, rand_byte(), rand_byte());
         end else begin
            j++;
            if (roll < 13)
               push_load(rand_byte(), rand_byte());
            else if (roll < 17)
               push_req(sstb_pkg::CMD_START, rand_byte(), rand_byte());
            else if ($urandom_range(99) < 15)
               push_pixel(cfg_mode[sstb_pkg::PIX_W-1:0]);
            else
               push_pixel(rand_byte());
         end
      end
   endtask

   initial begin : stimulus
      req_bus.valid       = 1'b0;
      req_bus.command     = sstb_pkg::CMD_PIXEL;
      req_bus.table_index = '0;
      req_bus.value       = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = sstb_pkg::REG_DEST_X;
      csr_bus.data        = '0;
      hold_req            = 1'b0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      mismatch_count      = 0;
      cfg_dest_x = 0;
      cfg_dest_y = 0;
      cfg_pic_w  = 1;
      cfg_pic_h  = 1;
      cfg_scale  = 1;
      cfg_scr_w  = 320;
      cfg_scr_h  = 200;
      cfg_mode   = 255;
      src_col    = 0;
      src_row    = 0;
      foreach (tbl_loaded[i])
         tbl_loaded[i] = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: one-pixel picture, key 255, no translation
      @(negedge clock);
      push_pixel(8'h00);
      push_pixel(8'hFF);
      push_pixel(8'hAA);
      push_pixel(8'h55);
      push_req(CMD_UNUSED, 8'hFF, 8'h00);
      push_req(sstb_pkg::CMD_START, 8'h00, 8'hFF);
      push_pixel(8'h01);

      // origin near the bottom right corner, key 0, translation on
      setup(318, 198, 3, 2, 2, 320, 200, 9'h100);
      @(negedge clock);
      push_load(8'h00, 8'hFF);
      push_load(8'hFF, 8'h00);
      push_load(8'hAA, 8'h55);
      push_load(8'h55, 8'hAA);
      push_pixel(8'hFF);
      push_pixel(8'hAA);
      push_pixel(8'h00);
      push_pixel(8'h55);
      push_pixel(8'hFF);
      push_pixel(8'hAA);
      push_pixel(8'h55);
      push_req(sstb_pkg::CMD_START, 8'hFF, 8'hFF);
      push_pixel(8'hFF);

      // widest screen, largest scale
      setup(0, 0, 8, 4, 8, 16'hFFFF, 4096, 9'h0FF);
      run_phase(0, 0, 20);
      // origin at the far corner, size and scale out of range
      setup(16'hFFFF, 16'hFFFF, 0, 2047, 0, 4096, 4096, 9'h1FF);
      run_phase(83, 0, 20);
      random_setup();
      run_phase(0, 83, 25);
      // zero-width screen drops every write
      setup($urandom_range(400), $urandom_range(300), 4, 3, 3, 0, 480, $urandom_range(511));
      run_phase(21, 21, 15);
      random_setup();
      run_phase(0, 0, 25);
      hold_req = 1'b1;
      random_setup();
      csr_write(sstb_pkg::REG_SCALE_FACTOR, 16'hFFFF);
      run_phase(83, 0, 25);
      random_setup();
      run_phase(0, 83, 25);
      random_setup();
      run_phase(21, 21, 25);

      for (int c = 0; c < 200000 && blit_busy(); c++)
         @(negedge clock);
      repeat (16) @(posedge clock);
      if (fb_expect_q.size() != 0)
         report_mismatch($sformatf("%0d expected writes never arrived", fb_expect_q.size()));
      if (mismatch_count == 0)
         $display("[scaled_transparent_sprite_blitter_top] OK");
      else
         $display("[scaled_transparent_sprite_blitter_top] ERROR");
      $finish;
   end

endmodule
